// ===== rtl/smrc_pkg.sv =====
// shared types and codes of the shadow memory range checker
package smrc_pkg;

    // access kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNINIT   = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic        func;
        logic [31:0] address;
        logic [7:0]  type_id;
        logic [15:0] type_size;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] stored_type;
    } t_rsp;

    // scan token handed from cell to cell
    typedef struct packed {
        logic       act;
        logic       slot_found;
        logic       hit_found;
        logic [7:0] hit_type;
    } t_tok;

endpackage

// ===== rtl/smrc_in_if.sv =====
// request channel interface
interface smrc_in_if;
    logic            valid;
    logic            ready;
    smrc_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/smrc_out_if.sv =====
// response channel interface
interface smrc_out_if;
    logic            valid;
    logic            ready;
    smrc_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/shadow_memory_range_checker.sv =====
// shadow memory range checker: controller and chain of table cells
//
// usage
// - i_req carries one access per transfer: func (0 write, 1 read), address,
//   type_id and type_size; o_rsp returns status and stored_type for each one
// - a write drops every stored range that overlaps [address, address+size)
//   or starts at address, then takes the lowest entry that is free or
//   dropped; with no such entry it reports table full and changes nothing
// - a read reports ok, uninitialised or type mismatch for the entry that
//   starts exactly at address
// scan and flow
// - a scan token walks the row of TABLE_ENTRIES cells, one cell a cycle;
//   a new access is taken only once the last one has left the row and
//   its response has gone into the output register
// - i_req.ready is high only while no scan is in flight
// reset
// - synchronous, active low; all entries become invalid at once
// stalls
// - the response sits in an output register; a new request is taken while
//   it waits, but the next table update holds until the response is taken
module shadow_memory_range_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smrc_in_if.sink    i_req,
    smrc_out_if.source o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]     r_state;
    smrc_pkg::t_req r_req;
    logic           r_start;
    smrc_pkg::t_tok r_fin;
    logic           r_out_valid;
    smrc_pkg::t_rsp r_out;
    smrc_pkg::t_rsp n_out;

    // token at the head of each cell, last one leaves the row
    smrc_pkg::t_tok w_tok [0:TABLE_ENTRIES];

    logic w_in_xfer;
    logic w_out_free;
    logic w_finish;
    logic w_commit;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_xfer   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_finish    = (r_state == S_FIN) && w_out_free;
    // table changes only on a write that found a slot
    assign w_commit    = w_finish && (r_req.func == smrc_pkg::FUNC_WRITE) && r_fin.slot_found;

    // fresh token enters cell 0 the cycle after the transfer
    always_comb begin
        w_tok[0]     = '0;
        w_tok[0].act = r_start;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        smrc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .o_tok    (w_tok[g+1]),
            .i_req    (r_req),
            .i_commit (w_commit)
        );
    end

    // response from the token that left the last cell
    always_comb begin
        n_out.status      = smrc_pkg::STATUS_OK;
        n_out.stored_type = 8'd0;
        if (r_req.func == smrc_pkg::FUNC_READ) begin
            if (!r_fin.hit_found) begin
                n_out.status = smrc_pkg::STATUS_UNINIT;
            end else begin
                n_out.stored_type = r_fin.hit_type;
                if (r_fin.hit_type != r_req.type_id) begin
                    n_out.status = smrc_pkg::STATUS_MISMATCH;
                end
            end
        end else if (!r_fin.slot_found) begin
            n_out.status = smrc_pkg::STATUS_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= w_in_xfer;
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[TABLE_ENTRIES].act) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req <= i_req.data;
        end
        if ((r_state == S_SCAN) && w_tok[TABLE_ENTRIES].act) begin
            r_fin <= w_tok[TABLE_ENTRIES];
        end
        if (w_finish) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

// ===== rtl/smrc_cell.sv =====
// one table entry with its overlap and match logic
module smrc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smrc_pkg::t_tok i_tok,
    output smrc_pkg::t_tok o_tok,
    input  smrc_pkg::t_req i_req,
    input  logic           i_commit
);

    logic        r_valid;
    logic [31:0] r_start;
    logic [15:0] r_size;
    logic [7:0]  r_type;
    logic        r_kill;
    logic        r_sel;
    smrc_pkg::t_tok r_tok;
    smrc_pkg::t_tok n_tok;

    logic [32:0] w_end_s;
    logic [32:0] w_end_q;
    logic        w_eq;
    logic        w_meet;
    logic        w_kill;
    logic        w_free;
    logic        w_match;

    // 33-bit ends, no wrap at the top of the address space
    assign w_end_s = {1'b0, r_start} + {17'd0, r_size};
    assign w_end_q = {1'b0, i_req.address} + {17'd0, i_req.type_size};
    assign w_eq    = (r_start == i_req.address);
    assign w_meet  = ({1'b0, r_start} < w_end_q) && ({1'b0, i_req.address} < w_end_s);
    assign w_kill  = r_valid && (w_eq || w_meet);
    assign w_free  = !r_valid;
    assign w_match = r_valid && w_eq;

    always_comb begin
        n_tok            = i_tok;
        n_tok.slot_found = i_tok.slot_found || w_free || w_kill;
        n_tok.hit_found  = i_tok.hit_found || w_match;
        if (i_tok.hit_found) begin
            n_tok.hit_type = i_tok.hit_type;
        end else if (w_match) begin
            n_tok.hit_type = r_type;
        end else begin
            n_tok.hit_type = 8'd0;
        end
        if (!i_tok.act) begin
            n_tok = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
            r_kill  <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.act) begin
                r_kill <= w_kill;
                r_sel  <= !i_tok.slot_found && (w_free || w_kill);
            end
            if (i_commit) begin
                if (r_sel) begin
                    r_valid <= 1'b1;
                end else if (r_kill) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit && r_sel) begin
            r_start <= i_req.address;
            r_size  <= i_req.type_size;
            r_type  <= i_req.type_id;
        end
    end

    assign o_tok = r_tok;

endmodule
